### hw/rtl/usdw_pkg.sv
package usdw_pkg;

   // Width of the running sum.
   localparam int unsigned SumBits = 16;
   localparam logic [SumBits-1:0] SumMax = {SumBits{1'b1}};

   // Width class of one code point.
   localparam logic [1:0] CLS_ZERO    = 2'd0;
   localparam logic [1:0] CLS_ONE     = 2'd1;
   localparam logic [1:0] CLS_TWO     = 2'd2;
   localparam logic [1:0] CLS_INVALID = 2'd3;

   // One classified beat as it passes from the front end to the back end.
   typedef struct packed {
      logic [1:0] cls;
      logic       is_nul;
      logic       last;
   } item_type;

   localparam int unsigned SpanCount = 149;

   typedef struct packed {
      logic [19:0] lo;
      logic [19:0] hi;
      logic        wide;
   } span_type;

   typedef span_type span_array_type [SpanCount];

   localparam span_array_type Spans = '{
      '{20'h0300,20'h036F,1'b0},'{20'h0483,20'h0486,1'b0},'{20'h0488,20'h0489,1'b0},
      '{20'h0591,20'h05BD,1'b0},'{20'h05BF,20'h05BF,1'b0},'{20'h05C1,20'h05C2,1'b0},
      '{20'h05C4,20'h05C5,1'b0},'{20'h05C7,20'h05C7,1'b0},'{20'h0600,20'h0603,1'b0},
      '{20'h0610,20'h0615,1'b0},'{20'h064B,20'h065E,1'b0},'{20'h0670,20'h0670,1'b0},
      '{20'h06D6,20'h06E4,1'b0},'{20'h06E7,20'h06E8,1'b0},'{20'h06EA,20'h06ED,1'b0},
      '{20'h070F,20'h070F,1'b0},'{20'h0711,20'h0711,1'b0},'{20'h0730,20'h074A,1'b0},
      '{20'h07A6,20'h07B0,1'b0},'{20'h07EB,20'h07F3,1'b0},'{20'h0901,20'h0902,1'b0},
      '{20'h093C,20'h093C,1'b0},'{20'h0941,20'h0948,1'b0},'{20'h094D,20'h094D,1'b0},
      '{20'h0951,20'h0954,1'b0},'{20'h0962,20'h0963,1'b0},'{20'h0981,20'h0981,1'b0},
      '{20'h09BC,20'h09BC,1'b0},'{20'h09C1,20'h09C4,1'b0},'{20'h09CD,20'h09CD,1'b0},
      '{20'h09E2,20'h09E3,1'b0},'{20'h0A01,20'h0A02,1'b0},'{20'h0A3C,20'h0A3C,1'b0},
      '{20'h0A41,20'h0A42,1'b0},'{20'h0A47,20'h0A48,1'b0},'{20'h0A4B,20'h0A4D,1'b0},
      '{20'h0A70,20'h0A71,1'b0},'{20'h0A81,20'h0A82,1'b0},'{20'h0ABC,20'h0ABC,1'b0},
      '{20'h0AC1,20'h0AC5,1'b0},'{20'h0AC7,20'h0AC8,1'b0},'{20'h0ACD,20'h0ACD,1'b0},
      '{20'h0AE2,20'h0AE3,1'b0},'{20'h0B01,20'h0B01,1'b0},'{20'h0B3C,20'h0B3C,1'b0},
      '{20'h0B3F,20'h0B3F,1'b0},'{20'h0B41,20'h0B43,1'b0},'{20'h0B4D,20'h0B4D,1'b0},
      '{20'h0B56,20'h0B56,1'b0},'{20'h0B82,20'h0B82,1'b0},'{20'h0BC0,20'h0BC0,1'b0},
      '{20'h0BCD,20'h0BCD,1'b0},'{20'h0C3E,20'h0C40,1'b0},'{20'h0C46,20'h0C48,1'b0},
      '{20'h0C4A,20'h0C4D,1'b0},'{20'h0C55,20'h0C56,1'b0},'{20'h0CBC,20'h0CBC,1'b0},
      '{20'h0CBF,20'h0CBF,1'b0},'{20'h0CC6,20'h0CC6,1'b0},'{20'h0CCC,20'h0CCD,1'b0},
      '{20'h0CE2,20'h0CE3,1'b0},'{20'h0D41,20'h0D43,1'b0},'{20'h0D4D,20'h0D4D,1'b0},
      '{20'h0DCA,20'h0DCA,1'b0},'{20'h0DD2,20'h0DD4,1'b0},'{20'h0DD6,20'h0DD6,1'b0},
      '{20'h0E31,20'h0E31,1'b0},'{20'h0E34,20'h0E3A,1'b0},'{20'h0E47,20'h0E4E,1'b0},
      '{20'h0EB1,20'h0EB1,1'b0},'{20'h0EB4,20'h0EB9,1'b0},'{20'h0EBB,20'h0EBC,1'b0},
      '{20'h0EC8,20'h0ECD,1'b0},'{20'h0F18,20'h0F19,1'b0},'{20'h0F35,20'h0F35,1'b0},
      '{20'h0F37,20'h0F37,1'b0},'{20'h0F39,20'h0F39,1'b0},'{20'h0F71,20'h0F7E,1'b0},
      '{20'h0F80,20'h0F84,1'b0},'{20'h0F86,20'h0F87,1'b0},'{20'h0F90,20'h0F97,1'b0},
      '{20'h0F99,20'h0FBC,1'b0},'{20'h0FC6,20'h0FC6,1'b0},'{20'h102D,20'h1030,1'b0},
      '{20'h1032,20'h1032,1'b0},'{20'h1036,20'h1037,1'b0},'{20'h1039,20'h1039,1'b0},
      '{20'h1058,20'h1059,1'b0},'{20'h1100,20'h115F,1'b1},'{20'h1160,20'h11FF,1'b0},
      '{20'h135F,20'h135F,1'b0},'{20'h1712,20'h1714,1'b0},'{20'h1732,20'h1734,1'b0},
      '{20'h1752,20'h1753,1'b0},'{20'h1772,20'h1773,1'b0},'{20'h17B4,20'h17B5,1'b0},
      '{20'h17B7,20'h17BD,1'b0},'{20'h17C6,20'h17C6,1'b0},'{20'h17C9,20'h17D3,1'b0},
      '{20'h17DD,20'h17DD,1'b0},'{20'h180B,20'h180D,1'b0},'{20'h18A9,20'h18A9,1'b0},
      '{20'h1920,20'h1922,1'b0},'{20'h1927,20'h1928,1'b0},'{20'h1932,20'h1932,1'b0},
      '{20'h1939,20'h193B,1'b0},'{20'h1A17,20'h1A18,1'b0},'{20'h1B00,20'h1B03,1'b0},
      '{20'h1B34,20'h1B34,1'b0},'{20'h1B36,20'h1B3A,1'b0},'{20'h1B3C,20'h1B3C,1'b0},
      '{20'h1B42,20'h1B42,1'b0},'{20'h1B6B,20'h1B73,1'b0},'{20'h1DC0,20'h1DCA,1'b0},
      '{20'h1DFE,20'h1DFF,1'b0},'{20'h200B,20'h200F,1'b0},'{20'h202A,20'h202E,1'b0},
      '{20'h2060,20'h2063,1'b0},'{20'h206A,20'h206F,1'b0},'{20'h20D0,20'h20EF,1'b0},
      '{20'h2329,20'h232A,1'b1},'{20'h2E80,20'h3029,1'b1},'{20'h302A,20'h302F,1'b0},
      '{20'h3030,20'h303E,1'b1},'{20'h3099,20'h309A,1'b0},'{20'hA806,20'hA806,1'b0},
      '{20'hA80B,20'hA80B,1'b0},'{20'hA825,20'hA826,1'b0},'{20'hF900,20'hFAFF,1'b1},
      '{20'hFB1E,20'hFB1E,1'b0},'{20'hFE00,20'hFE0F,1'b0},'{20'hFE20,20'hFE23,1'b0},
      '{20'hFE30,20'hFE6F,1'b1},'{20'hFEFF,20'hFEFF,1'b0},'{20'hFF00,20'hFF60,1'b1},
      '{20'hFFE0,20'hFFE6,1'b1},'{20'h10A01,20'h10A03,1'b0},'{20'h10A05,20'h10A06,1'b0},
      '{20'h10A0C,20'h10A0F,1'b0},'{20'h10A38,20'h10A3A,1'b0},'{20'h10A3F,20'h10A3F,1'b0},
      '{20'h1D167,20'h1D169,1'b0},'{20'h1D173,20'h1D182,1'b0},'{20'h1D185,20'h1D18B,1'b0},
      '{20'h1D1AA,20'h1D1AD,1'b0},'{20'h1D242,20'h1D244,1'b0},'{20'hE0001,20'hE0001,1'b0},
      '{20'hE0020,20'hE007F,1'b0},'{20'hE0100,20'hE01EF,1'b0}
   };

endpackage

### hw/rtl/usdw_classify.sv
module usdw_classify (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  logic [31:0]           in_code_point,
   input  logic                  in_end_of_string,
   output logic                  out_valid,
   input  logic                  out_stall,
   output usdw_pkg::item_type    out_item
);
   import usdw_pkg::*;

   logic       valid_ff, valid_in;
   item_type   item_ff, item_in;
   logic       hit;
   logic       hit_wide;
   logic       printable;
   logic       control;
   logic [31:0] c;

   assign c = in_code_point;

   // Control and non-printable ranges.
   always_comb begin
      control = (c < 32'h20) || (c >= 32'h7F && c <= 32'h9F) ||
                (c == 32'h2028) || (c == 32'h2029) ||
                (c >= 32'hFFF9 && c <= 32'hFFFB);
      printable = !(c > 32'h10FFFF || (c >= 32'hD800 && c <= 32'hDFFF) ||
                    (c[15:1] == 15'h7FFF)) && !control;
   end

   // The range table is a bank of parallel compares; the spans are disjoint.
   always_comb begin
      hit = 1'b0;
      hit_wide = 1'b0;
      for (int i = 0; i < SpanCount; i++) begin
         if (c[31:20] == 12'd0 && c[19:0] >= Spans[i].lo && c[19:0] <= Spans[i].hi) begin
            hit = 1'b1;
            hit_wide = hit_wide | Spans[i].wide;
         end
      end
   end

   // Width class of the incoming beat.
   always_comb begin
      item_in.last = in_end_of_string;
      item_in.is_nul = (c == 32'd0);
      priority if (c >= 32'h20 && c <= 32'h7E) item_in.cls = CLS_ONE;
      else if (!printable) item_in.cls = (c != 32'd0) ? CLS_INVALID : CLS_ZERO;
      else if (c >= 32'h20000 && c <= 32'h3FFFF) item_in.cls = CLS_TWO;
      else if (hit) item_in.cls = hit_wide ? CLS_TWO : CLS_ZERO;
      else if (c >= 32'h3040 && c <= 32'hD7FF) item_in.cls = CLS_TWO;
      else item_in.cls = CLS_ONE;
   end

   assign in_stall = valid_ff && out_stall;
   assign valid_in = in_valid ? 1'b1 : (valid_ff && out_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item = item_ff;
endmodule

### hw/rtl/usdw_fifo.sv
module usdw_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  usdw_pkg::item_type    in_item,
   output logic                  out_valid,
   input  logic                  out_stall,
   output usdw_pkg::item_type    out_item
);
   import usdw_pkg::*;

   // Two-entry queue between the classifier and the accumulator.
   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_stall = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item = slot_ff[rd_ptr_ff];
   assign push = in_valid && !in_stall;
   assign pop = out_valid && !out_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end
endmodule

### hw/rtl/usdw_accum.sv
module usdw_accum (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  usdw_pkg::item_type    in_item,
   output logic                  out_valid,
   input  logic                  out_stall,
   output logic [15:0]           out_total_width,
   output logic                  out_has_invalid
);
   import usdw_pkg::*;

   logic [SumBits-1:0] sum_ff, sum_in;
   logic               stop_ff, stop_in;
   logic               inv_ff, inv_in;
   logic               rvalid_ff;
   logic [15:0]        rtotal_ff;
   logic               rinv_ff;
   logic               take;
   logic [SumBits:0]   wide_sum;
   logic [1:0]         add;

   assign in_stall = rvalid_ff && out_stall;
   assign take = in_valid && !in_stall;

   // Saturating sum and stop logic for one beat.
   always_comb begin
      add = (in_item.cls == CLS_TWO) ? 2'd2 : (in_item.cls == CLS_ONE) ? 2'd1 : 2'd0;
      wide_sum = {1'b0, sum_ff} + (SumBits+1)'(add);
      sum_in = sum_ff;
      stop_in = stop_ff;
      inv_in = inv_ff;
      if (!stop_ff) begin
         if (in_item.is_nul) begin
            stop_in = 1'b1;
         end else if (in_item.cls == CLS_INVALID) begin
            stop_in = 1'b1;
            inv_in = 1'b1;
         end else begin
            sum_in = wide_sum[SumBits] ? SumMax : wide_sum[SumBits-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         stop_ff <= 1'b0;
         inv_ff <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         if (take) begin
            if (in_item.last) begin
               sum_ff <= '0;
               stop_ff <= 1'b0;
               inv_ff <= 1'b0;
            end else begin
               sum_ff <= sum_in;
               stop_ff <= stop_in;
               inv_ff <= inv_in;
            end
         end
         if (!in_stall) begin
            rvalid_ff <= take && in_item.last;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (take && in_item.last) begin
         rtotal_ff <= 16'(sum_in);
         rinv_ff <= inv_in;
      end
   end

   assign out_valid = rvalid_ff;
   assign out_total_width = rtotal_ff;
   assign out_has_invalid = rinv_ff;
endmodule

### hw/rtl/unicode_string_display_width_core.sv
// Display-width accumulator: one 32-bit code point is taken per cycle while
// req_stall is low, and on the beat marked end_of_string the column total of
// that string is returned with a flag for a non-printable character. The range
// compare bank and the saturating adder are combinational; a beat passes the
// classifier register, the two-entry queue and the result register in turn.
// A NUL or an invalid character stops counting until the string ends; the sum
// saturates at its maximum.
module unicode_string_display_width_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_code_point,
   input  logic        req_end_of_string,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_total_width,
   output logic        rsp_has_invalid
);
   import usdw_pkg::*;

   logic     cls_valid, cls_stall;
   item_type cls_item;
   logic     q_valid, q_stall;
   item_type q_item;

   usdw_classify u_classify (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_stall(req_stall),
      .in_code_point(req_code_point), .in_end_of_string(req_end_of_string),
      .out_valid(cls_valid), .out_stall(cls_stall), .out_item(cls_item)
   );

   usdw_fifo u_fifo (
      .clock(clock), .reset(reset),
      .in_valid(cls_valid), .in_stall(cls_stall), .in_item(cls_item),
      .out_valid(q_valid), .out_stall(q_stall), .out_item(q_item)
   );

   usdw_accum u_accum (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_stall(q_stall), .in_item(q_item),
      .out_valid(rsp_valid), .out_stall(rsp_stall),
      .out_total_width(rsp_total_width), .out_has_invalid(rsp_has_invalid)
   );
endmodule
